// ----- rtl/tmd_pkg.sv -----
// Package for the tunnel message deframer: event codes, message types,
// parser phases, header sub-steps and the result item structure.
// Depends on nothing.
package tmd_pkg;

   // Event reported with every result item.
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_PAYLOAD   = 3'd1,
      EV_INIT_OK   = 3'd2,
      EV_INIT_BAD  = 3'd3,
      EV_RECONNECT = 3'd4,
      EV_CLOSE     = 3'd5,
      EV_BAD_TYPE  = 3'd6,
      EV_DROPPED   = 3'd7
   } event_type;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_INIT = 2'd0,
      PH_DATA = 2'd1,
      PH_DEAD = 2'd2
   } phase_type;

   // Message type bytes.
   localparam logic [7:0] MT_DATA      = 8'd0;
   localparam logic [7:0] MT_INIT      = 8'd1;
   localparam logic [7:0] MT_RECONNECT = 8'd2;
   localparam logic [7:0] MT_CLOSE     = 8'd3;

   // Init header byte positions.
   localparam logic [2:0] HDR_TYPE     = 3'd0;
   localparam logic [2:0] HDR_LEN_HI   = 3'd1;
   localparam logic [2:0] HDR_LEN_LO   = 3'd2;
   localparam logic [2:0] HDR_MAGIC_HI = 3'd3;
   localparam logic [2:0] HDR_MAGIC_LO = 3'd4;
   localparam logic [2:0] HDR_WIN_HI   = 3'd5;

   // Data mode sub-steps.
   localparam logic [2:0] DAT_TYPE   = 3'd0;
   localparam logic [2:0] DAT_LEN_HI = 3'd1;
   localparam logic [2:0] DAT_LEN_LO = 3'd2;
   localparam logic [2:0] DAT_BODY   = 3'd3;

   // Magic value after reset.
   localparam logic [15:0] MAGIC_RESET = 16'h2a75;

   // One result item.
   typedef struct packed {
      event_type   event_res;
      logic [7:0]  data_byte;
      logic        last_of_message;
      logic [15:0] send_window;
   } result_type;

endpackage

// ----- rtl/tunnel_message_deframer_unit.sv -----
// Top level of the tunnel message deframer: input register, parser and
// result register. Depends on tmd_pkg and tmd_parser.
//
// A byte waits in the input register, then passes through the parser into the
// result register, which offers its result item; a stalled receiver holds it back.
// Throughput: one byte per cycle while the receiver does not stall; the input and
// result registers both hold an item, so a byte is taken while a finished result still waits.
// Reset: synchronous, active high; clears the parser to await an init header,
// empties both registers and restores the expected magic to 0x2a75.
module tunnel_message_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_of_message,
   output logic [15:0] rsp_send_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_magic
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   tmd_pkg::result_type out_result_ff;
   tmd_pkg::result_type result;
   logic [15:0] magic_ff;
   logic        out_free;
   logic        advance;

   // Movement between the two registers.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // Expected magic register.
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= tmd_pkg::MAGIC_RESET;
      end else if (csr_valid && csr_ready) begin
         magic_ff <= csr_expected_magic;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   tmd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .expected_magic (magic_ff),
      .result         (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_res       = out_result_ff.event_res;
   assign rsp_data_byte       = out_result_ff.data_byte;
   assign rsp_last_of_message = out_result_ff.last_of_message;
   assign rsp_send_window     = out_result_ff.send_window;

endmodule

// ----- rtl/tmd_parser.sv -----
// Deframer parsing state and its single-pass next-state logic.
// Depends on tmd_pkg.
module tmd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  logic [15:0]        expected_magic,
   output tmd_pkg::result_type result
);

   tmd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic        init_type_ok_ff, init_type_ok_in;
   logic [7:0]  high_byte_hold_ff, high_byte_hold_in;
   logic [15:0] magic_seen_ff, magic_seen_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic [15:0] window_value_ff, window_value_in;
   logic [15:0] length_value;
   tmd_pkg::event_type event_res;
   logic [7:0]  data_byte;
   logic        last_flag;

   assign length_value = {high_byte_hold_ff, rx_byte};

   // Next state and result for the item now in the input register.
   always_comb begin
      phase_in          = phase_ff;
      header_count_in   = header_count_ff;
      init_type_ok_in   = init_type_ok_ff;
      high_byte_hold_in = high_byte_hold_ff;
      magic_seen_in     = magic_seen_ff;
      payload_left_in   = payload_left_ff;
      window_value_in   = window_value_ff;
      event_res         = tmd_pkg::EV_NONE;
      data_byte         = 8'd0;
      last_flag         = 1'b0;
      case (phase_ff)
         tmd_pkg::PH_INIT: begin
            case (header_count_ff)
               tmd_pkg::HDR_TYPE: begin
                  init_type_ok_in = (rx_byte == tmd_pkg::MT_INIT);
                  header_count_in = tmd_pkg::HDR_LEN_HI;
               end
               tmd_pkg::HDR_LEN_HI, tmd_pkg::HDR_LEN_LO: begin
                  header_count_in = header_count_ff + 3'd1;
               end
               tmd_pkg::HDR_MAGIC_HI: begin
                  magic_seen_in   = {rx_byte, 8'd0};
                  header_count_in = tmd_pkg::HDR_MAGIC_LO;
               end
               tmd_pkg::HDR_MAGIC_LO: begin
                  magic_seen_in   = {magic_seen_ff[15:8], rx_byte};
                  header_count_in = tmd_pkg::HDR_WIN_HI;
               end
               tmd_pkg::HDR_WIN_HI: begin
                  high_byte_hold_in = rx_byte;
                  header_count_in   = header_count_ff + 3'd1;
               end
               default: begin
                  // Final header byte, or a count beyond the header.
                  if (init_type_ok_ff && (magic_seen_ff == expected_magic)) begin
                     window_value_in = length_value;
                     phase_in        = tmd_pkg::PH_DATA;
                     event_res       = tmd_pkg::EV_INIT_OK;
                  end else begin
                     phase_in  = tmd_pkg::PH_DEAD;
                     event_res = tmd_pkg::EV_INIT_BAD;
                  end
                  header_count_in = tmd_pkg::HDR_TYPE;
               end
            endcase
         end
         tmd_pkg::PH_DATA: begin
            case (header_count_ff)
               tmd_pkg::DAT_TYPE: begin
                  if (rx_byte == tmd_pkg::MT_DATA) begin
                     header_count_in = tmd_pkg::DAT_LEN_HI;
                  end else if (rx_byte == tmd_pkg::MT_RECONNECT) begin
                     event_res       = tmd_pkg::EV_RECONNECT;
                     phase_in        = tmd_pkg::PH_INIT;
                     header_count_in = tmd_pkg::HDR_TYPE;
                     init_type_ok_in = 1'b0;
                  end else if (rx_byte == tmd_pkg::MT_CLOSE) begin
                     event_res = tmd_pkg::EV_CLOSE;
                  end else begin
                     event_res = tmd_pkg::EV_BAD_TYPE;
                  end
               end
               tmd_pkg::DAT_LEN_HI: begin
                  high_byte_hold_in = rx_byte;
                  header_count_in   = tmd_pkg::DAT_LEN_LO;
               end
               tmd_pkg::DAT_LEN_LO: begin
                  // An empty message goes straight back to the type byte.
                  payload_left_in = length_value;
                  header_count_in = (length_value == 16'd0) ? tmd_pkg::DAT_TYPE
                                                            : tmd_pkg::DAT_BODY;
               end
               default: begin
                  event_res = tmd_pkg::EV_PAYLOAD;
                  data_byte = rx_byte;
                  if (payload_left_ff != 16'd0) begin
                     payload_left_in = payload_left_ff - 16'd1;
                  end
                  if ((payload_left_ff == 16'd0) || (payload_left_ff == 16'd1)) begin
                     last_flag       = 1'b1;
                     header_count_in = tmd_pkg::DAT_TYPE;
                  end
               end
            endcase
         end
         default: begin
            event_res = tmd_pkg::EV_DROPPED;
         end
      endcase
   end

   assign result.event_res       = event_res;
   assign result.data_byte       = data_byte;
   assign result.last_of_message = last_flag;
   assign result.send_window     = window_value_in;

   // State registers advance once per item passed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= tmd_pkg::PH_INIT;
         header_count_ff   <= 3'd0;
         init_type_ok_ff   <= 1'b0;
         high_byte_hold_ff <= 8'd0;
         magic_seen_ff     <= 16'd0;
         payload_left_ff   <= 16'd0;
         window_value_ff   <= 16'd0;
      end else if (step) begin
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         init_type_ok_ff   <= init_type_ok_in;
         high_byte_hold_ff <= high_byte_hold_in;
         magic_seen_ff     <= magic_seen_in;
         payload_left_ff   <= payload_left_in;
         window_value_ff   <= window_value_in;
      end
   end

endmodule

// ----- rtl/tmd_checker.sv -----
// Port-level checks for the tunnel message deframer, bound to its top level.
// Depends on tmd_pkg and tunnel_message_deframer_unit.
module tmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_last_of_message,
   input logic [15:0] rsp_send_window
);

   // No result item is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("result offered straight after reset");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_data_byte) && $stable(rsp_last_of_message)
         && $stable(rsp_send_window))
      else $error("stalled result item changed");

   // Only payload items carry data.
   a_no_stray_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != tmd_pkg::EV_PAYLOAD) |->
         (rsp_data_byte == 8'd0) && !rsp_last_of_message)
      else $error("data on a non-payload item");

   // No window is latched while the first header is still being read.
   a_window_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == tmd_pkg::EV_INIT_BAD)
         || (rsp_event_res == tmd_pkg::EV_DROPPED)) && $past(reset, 8)
         |-> rsp_send_window == 16'd0)
      else $error("window set before any accepted header");

endmodule

bind tunnel_message_deframer_unit tmd_checker u_tmd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_event_res       (rsp_event_res),
   .rsp_data_byte       (rsp_data_byte),
   .rsp_last_of_message (rsp_last_of_message),
   .rsp_send_window     (rsp_send_window)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for tunnel_message_deframer_unit: a directed table, then random
// traffic, checked against a behavioural deframer model or typed table rows. Depends on tmd_pkg and the RTL.
module tb;

   // Last byte of the init header; the package stops at the window high byte.
   localparam logic [2:0] HDR_WIN_LO = tmd_pkg::HDR_WIN_HI + 3'd1;
   // Cycles allowed after the last result before anything else happens.
   localparam int SETTLE_CYCLES = 4;

   // One directed byte, with its result typed in where it is obvious.
   typedef struct packed {
      logic [7:0]         rx;
      logic               typed;
      tmd_pkg::event_type ev;
      logic [7:0]         data;
      logic               last;
      logic [15:0]        win;
   } dir_row_type;

   localparam int DIR_ROWS = 19;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // Good init header at the reset magic, window at its top value.
      '{8'h01, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'h2a, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'h75, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'hff, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'hff, 1'b1, tmd_pkg::EV_INIT_OK,   8'h00, 1'b0, 16'hffff},
      // Two-byte data message; the payload is left to the model.
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      '{8'h02, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      '{8'hff, 1'b0, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      '{8'h00, 1'b0, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'h0000},
      // Zero-length data message.
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      '{8'h00, 1'b1, tmd_pkg::EV_NONE,      8'h00, 1'b0, 16'hffff},
      // Close, init type in data mode, unknown type, then reconnect.
      '{8'h03, 1'b1, tmd_pkg::EV_CLOSE,     8'h00, 1'b0, 16'hffff},
      '{8'h01, 1'b1, tmd_pkg::EV_BAD_TYPE,  8'h00, 1'b0, 16'hffff},
      '{8'hff, 1'b1, tmd_pkg::EV_BAD_TYPE,  8'h00, 1'b0, 16'hffff},
      '{8'h02, 1'b1, tmd_pkg::EV_RECONNECT, 8'h00, 1'b0, 16'hffff}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_of_message;
   logic [15:0] rsp_send_window;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_expected_magic = tmd_pkg::MAGIC_RESET;

   // Typed expectation travelling with the byte on the request side.
   logic                req_typed = 1'b0;
   tmd_pkg::result_type req_typed_res = '0;

   // Deframer model state.
   tmd_pkg::phase_type dfr_phase;
   logic [2:0]  dfr_step;
   logic        dfr_type_ok;
   logic [7:0]  dfr_high_hold;
   logic [15:0] dfr_magic_got;
   logic [15:0] dfr_body_left;
   logic [15:0] dfr_window;
   logic [15:0] dfr_magic_want;

   tmd_pkg::result_type awaited_results [$];
   int          fault_count = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [15:0] cur_magic = tmd_pkg::MAGIC_RESET;

   tunnel_message_deframer_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_send_window     (rsp_send_window),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_expected_magic  (csr_expected_magic)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, decided afresh at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Advances the deframer model by one received byte and gives its result.
   task automatic deframe_byte(input logic [7:0] b, output tmd_pkg::result_type r);
      r = '0;
      r.event_res = tmd_pkg::EV_NONE;
      case (dfr_phase)
         tmd_pkg::PH_INIT: begin
            case (dfr_step)
               tmd_pkg::HDR_TYPE: begin
                  dfr_type_ok = (b == tmd_pkg::MT_INIT);
                  dfr_step = tmd_pkg::HDR_LEN_HI;
               end
               tmd_pkg::HDR_LEN_HI, tmd_pkg::HDR_LEN_LO: begin
                  dfr_step = dfr_step + 3'd1;
               end
               tmd_pkg::HDR_MAGIC_HI: begin
                  dfr_magic_got = {b, 8'h00};
                  dfr_step = tmd_pkg::HDR_MAGIC_LO;
               end
               tmd_pkg::HDR_MAGIC_LO: begin
                  dfr_magic_got[7:0] = b;
                  dfr_step = tmd_pkg::HDR_WIN_HI;
               end
               tmd_pkg::HDR_WIN_HI: begin
                  dfr_high_hold = b;
                  dfr_step = HDR_WIN_LO;
               end
               default: begin
                  if (dfr_type_ok && dfr_magic_got == dfr_magic_want) begin
                     dfr_window = {dfr_high_hold, b};
                     dfr_phase = tmd_pkg::PH_DATA;
                     r.event_res = tmd_pkg::EV_INIT_OK;
                  end else begin
                     dfr_phase = tmd_pkg::PH_DEAD;
                     r.event_res = tmd_pkg::EV_INIT_BAD;
                  end
                  dfr_step = tmd_pkg::HDR_TYPE;
               end
            endcase
         end
         tmd_pkg::PH_DATA: begin
            case (dfr_step)
               tmd_pkg::DAT_TYPE: begin
                  if (b == tmd_pkg::MT_DATA) begin
                     dfr_step = tmd_pkg::DAT_LEN_HI;
                  end else if (b == tmd_pkg::MT_RECONNECT) begin
                     r.event_res = tmd_pkg::EV_RECONNECT;
                     dfr_phase = tmd_pkg::PH_INIT;
                     dfr_step = tmd_pkg::HDR_TYPE;
                     dfr_type_ok = 1'b0;
                  end else if (b == tmd_pkg::MT_CLOSE) begin
                     r.event_res = tmd_pkg::EV_CLOSE;
                  end else begin
                     r.event_res = tmd_pkg::EV_BAD_TYPE;
                  end
               end
               tmd_pkg::DAT_LEN_HI: begin
                  dfr_high_hold = b;
                  dfr_step = tmd_pkg::DAT_LEN_LO;
               end
               tmd_pkg::DAT_LEN_LO: begin
                  dfr_body_left = {dfr_high_hold, b};
                  dfr_step = (dfr_body_left == 16'd0) ? tmd_pkg::DAT_TYPE
                                                      : tmd_pkg::DAT_BODY;
               end
               default: begin
                  r.event_res = tmd_pkg::EV_PAYLOAD;
                  r.data_byte = b;
                  if (dfr_body_left != 16'd0) dfr_body_left = dfr_body_left - 16'd1;
                  if (dfr_body_left == 16'd0) begin
                     r.last_of_message = 1'b1;
                     dfr_step = tmd_pkg::DAT_TYPE;
                  end
               end
            endcase
         end
         default: begin
            r.event_res = tmd_pkg::EV_DROPPED;
         end
      endcase
      r.send_window = dfr_window;
   endtask

   // Compares one result item with its expectation, field by field.
   task automatic compare_result(input tmd_pkg::result_type want,
                                 input tmd_pkg::result_type got);
      if (got.event_res != want.event_res) begin
         $display("%0t: event_res expected %0d, got %0d", $time,
                  want.event_res, got.event_res);
         fault_count++;
      end
      if (got.data_byte != want.data_byte) begin
         $display("%0t: data_byte expected %h, got %h", $time,
                  want.data_byte, got.data_byte);
         fault_count++;
      end
      if (got.last_of_message != want.last_of_message) begin
         $display("%0t: last_of_message expected %b, got %b", $time,
                  want.last_of_message, got.last_of_message);
         fault_count++;
      end
      if (got.send_window != want.send_window) begin
         $display("%0t: send_window expected %h, got %h", $time,
                  want.send_window, got.send_window);
         fault_count++;
      end
   endtask

   // Watches all three channels at the rising edge and keeps the model in step.
   always @(posedge clock) begin
      tmd_pkg::result_type want;
      tmd_pkg::result_type got;
      if (reset) begin
         dfr_phase = tmd_pkg::PH_INIT;
         dfr_step = tmd_pkg::HDR_TYPE;
         dfr_type_ok = 1'b0;
         dfr_high_hold = 8'h00;
         dfr_magic_got = 16'h0000;
         dfr_body_left = 16'h0000;
         dfr_window = 16'h0000;
         dfr_magic_want = tmd_pkg::MAGIC_RESET;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.event_res = tmd_pkg::event_type'(rsp_event_res);
            got.data_byte = rsp_data_byte;
            got.last_of_message = rsp_last_of_message;
            got.send_window = rsp_send_window;
            if (awaited_results.size() == 0) begin
               $display("%0t: result item with none expected, event %0d", $time,
                        rsp_event_res);
               fault_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_result(want, got);
            end
         end
         if (csr_valid && csr_ready) dfr_magic_want = csr_expected_magic;
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte, want);
            if (req_typed) want = req_typed_res;
            awaited_results.push_back(want);
         end
      end
   end

   // Offers one byte from a falling edge and returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input tmd_pkg::result_type tr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = b;
      req_typed = typed;
      req_typed_res = tr;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_free(input logic [7:0] b);
      send_byte(b, 1'b0, '0);
   endtask

   task automatic send_header(input logic [7:0] kind, input logic [15:0] len,
                              input logic [15:0] magic, input logic [15:0] win);
      send_free(kind);
      send_free(len[15:8]);
      send_free(len[7:0]);
      send_free(magic[15:8]);
      send_free(magic[7:0]);
      send_free(win[15:8]);
      send_free(win[7:0]);
   endtask

   task automatic send_data_message(input logic [15:0] len);
      send_free(tmd_pkg::MT_DATA);
      send_free(len[15:8]);
      send_free(len[7:0]);
      for (int i = 0; i < int'(len); i++) send_free(8'($urandom_range(255)));
   endtask

   // Lets the pipe drain, then writes the expected magic.
   task automatic write_magic(input logic [15:0] m);
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_expected_magic = m;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_magic = m;
   endtask

   // Random traffic in data mode, whole messages at a time, with unknown type bytes mixed in.
   task automatic run_traffic(input int target);
      int pick;
      int size_pick;
      logic [7:0] kind;
      logic [15:0] len;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            size_pick = $urandom_range(99);
            if (size_pick < 75) len = 16'($urandom_range(8));
            else if (size_pick < 95) len = 16'($urandom_range(40, 9));
            else len = 16'($urandom_range(300, 256));
            send_data_message(len);
         end else if (pick < 80) begin
            send_free(tmd_pkg::MT_CLOSE);
         end else if (pick < 88) begin
            kind = 8'($urandom_range(255));
            if (kind == tmd_pkg::MT_DATA || kind == tmd_pkg::MT_RECONNECT
                || kind == tmd_pkg::MT_CLOSE) kind = tmd_pkg::MT_INIT;
            send_free(kind);
         end else begin
            send_free(tmd_pkg::MT_RECONNECT);
            send_header(tmd_pkg::MT_INIT, 16'($urandom_range(65535)), cur_magic,
                        16'($urandom_range(65535)));
         end
      end
   endtask

   initial begin
      dir_row_type row;
      tmd_pkg::result_type tr;
      logic [7:0] kind;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table at the reset magic.
      send_idle_pct = 35;
      recv_stall_pct = 85;
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TABLE[i];
         tr.event_res = row.ev;
         tr.data_byte = row.data;
         tr.last_of_message = row.last;
         tr.send_window = row.win;
         send_byte(row.rx, row.typed, tr);
      end

      // Sender idles lightly, receiver stalls heavily; magic at its top value.
      write_magic(16'hffff);
      send_header(tmd_pkg::MT_INIT, 16'($urandom_range(65535)), cur_magic,
                  16'($urandom_range(65535)));
      run_traffic(500);

      // The other way round, magic at zero.
      write_magic(16'h0000);
      send_idle_pct = 85;
      recv_stall_pct = 35;
      send_free(tmd_pkg::MT_RECONNECT);
      send_header(tmd_pkg::MT_INIT, 16'($urandom_range(65535)), cur_magic,
                  16'($urandom_range(65535)));
      run_traffic(1000);

      // No idling at all, random magic.
      write_magic(16'($urandom_range(65535)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_free(tmd_pkg::MT_RECONNECT);
      send_header(tmd_pkg::MT_INIT, 16'($urandom_range(65535)), cur_magic,
                  16'($urandom_range(65535)));
      run_traffic(1500);

      // A rejected header ends the useful life of the stream, so it comes last.
      send_free(tmd_pkg::MT_RECONNECT);
      if ($urandom_range(1) == 0) begin
         kind = 8'($urandom_range(255));
         if (kind == tmd_pkg::MT_INIT) kind = tmd_pkg::MT_DATA;
         send_header(kind, 16'($urandom_range(65535)), cur_magic,
                     16'($urandom_range(65535)));
      end else begin
         send_header(tmd_pkg::MT_INIT, 16'($urandom_range(65535)),
                     cur_magic ^ 16'($urandom_range(65535, 1)), 16'($urandom_range(65535)));
      end
      repeat (5) send_free(8'($urandom_range(255)));

      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- tunnel_message_deframer_unit.f -----
rtl/tmd_pkg.sv
rtl/tmd_parser.sv
rtl/tunnel_message_deframer_unit.sv
rtl/tmd_checker.sv
verif/tb.sv
